// File: design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 32;

   // control from the sequencer to the shared modular multiplier
   typedef struct packed {
      logic start;
   } mexp_mul_ctrl_type;

   // status from the shared modular multiplier back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } mexp_mul_stat_type;

endpackage

// File: design/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle from the
// most significant bit, double then conditionally add with reduction.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mexp_pkg::mexp_mul_ctrl_type   ctrl,
   input  logic [OPERAND_WIDTH-1:0]      op_a,
   input  logic [OPERAND_WIDTH-1:0]      op_b,
   input  logic [OPERAND_WIDTH-1:0]      modulus,
   output mexp_pkg::mexp_mul_stat_type   stat,
   output logic [OPERAND_WIDTH-1:0]      product
);
   import mexp_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int CNT_W = (W > 1) ? $clog2(W) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic [W-1:0]     a_ff, a_in;
   logic [W-1:0]     b_ff, b_in;
   logic [W-1:0]     m_ff, m_in;

   logic [W:0]       dbl;
   logic [W:0]       dbl_red;
   logic [W:0]       sum;
   logic [W:0]       sum_red;
   logic [W-1:0]     step;

   // one shift-and-add step
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? (dbl - {1'b0, m_ff}) : dbl;
      sum     = {1'b0, dbl_red[W-1:0]} + {1'b0, a_ff};
      sum_red = (sum >= {1'b0, m_ff}) ? (sum - {1'b0, m_ff}) : sum;
      step    = b_ff[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      if (busy_ff) begin
         acc_in = step;
         b_in   = {b_ff[W-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end else if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_LAST;
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         m_in    = modulus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;

endmodule

// File: design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply modular exponentiation on one shared
// bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// A transaction on req_ carries base, exponent and modulus; one transaction on
// rsp_ returns base^exponent mod modulus. A zero modulus returns 0.
// One item is worked on at a time: req_ready is high only while idle, and
// stays low until the result transaction on rsp_ has completed.
// Every modular product is one pass of the shared multiplier, one
// multiplier bit per cycle followed by a done strobe. The base is reduced
// first with one such pass, then each exponent bit costs one squaring and
// each set bit one more product; the squaring after the top set bit is
// skipped. The sequencer inspects each exponent bit in its step state and
// hands out the result once the exponent has reached zero. A zero exponent
// returns 1 mod modulus after the base reduction, and a zero modulus goes
// straight to the output.
// If the receiver stalls, the result is held in its output register with
// rsp_valid high and no new request is taken.
// Reset returns the sequencer and multiplier to idle; no other state is kept.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
   parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OPERAND_WIDTH-1:0] req_base_value,
   input  logic [OPERAND_WIDTH-1:0] req_exponent_value,
   input  logic [OPERAND_WIDTH-1:0] req_modulus_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [OPERAND_WIDTH-1:0] rsp_power_result
);
   import mexp_pkg::*;

   localparam int W = OPERAND_WIDTH;
   localparam logic [W-1:0] ONE = W'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_STEP,
      S_MULACC,
      S_SQUARE,
      S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [W-1:0]      acc_ff, acc_in;
   logic [W-1:0]      b_ff, b_in;
   logic [W-1:0]      e_ff, e_in;
   logic [W-1:0]      m_ff, m_in;
   logic [W-1:0]      res_ff, res_in;

   mexp_mul_ctrl_type mul_ctrl;
   mexp_mul_stat_type mul_stat;
   logic [W-1:0]      mul_a;
   logic [W-1:0]      mul_b;
   logic [W-1:0]      mul_m;
   logic [W-1:0]      mul_p;
   logic [W-1:0]      unit_val;

   mexp_mulmod #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mul_ctrl),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (mul_m),
      .stat    (mul_stat),
      .product (mul_p)
   );

   assign unit_val = (req_modulus_value == ONE) ? '0 : ONE;

   always_comb begin
      state_in       = state_ff;
      acc_in         = acc_ff;
      b_in           = b_ff;
      e_in           = e_ff;
      m_in           = m_ff;
      res_in         = res_ff;
      mul_ctrl.start = 1'b0;
      mul_a          = b_ff;
      mul_b          = b_ff;
      mul_m          = m_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               e_in   = req_exponent_value;
               m_in   = req_modulus_value;
               acc_in = unit_val;
               if (req_modulus_value == '0) begin
                  res_in   = '0;
                  state_in = S_OUT;
               end else begin
                  // base mod m as (1 mod m) * base mod m
                  mul_ctrl.start = 1'b1;
                  mul_a          = unit_val;
                  mul_b          = req_base_value;
                  mul_m          = req_modulus_value;
                  state_in       = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            if (mul_stat.done) begin
               b_in     = mul_p;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (e_ff == '0) begin
               res_in   = acc_ff;
               state_in = S_OUT;
            end else if (e_ff[0]) begin
               mul_ctrl.start = 1'b1;
               mul_a          = acc_ff;
               state_in       = S_MULACC;
            end else begin
               mul_ctrl.start = 1'b1;
               state_in       = S_SQUARE;
            end
         end
         S_MULACC: begin
            if (mul_stat.done) begin
               acc_in = mul_p;
               if ((e_ff >> 1) == '0) begin
                  e_in     = '0;
                  state_in = S_STEP;
               end else begin
                  mul_ctrl.start = 1'b1;
                  state_in       = S_SQUARE;
               end
            end
         end
         S_SQUARE: begin
            if (mul_stat.done) begin
               b_in     = mul_p;
               e_in     = e_ff >> 1;
               state_in = S_STEP;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff <= acc_in;
      b_ff   <= b_in;
      e_ff   <= e_in;
      m_ff   <= m_in;
      res_ff <= res_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_power_result = res_ff;

endmodule
